// ===== design/bfr_pkg.sv =====
// Shared types and constants for the bus frame receiver.
`default_nettype none
package bfr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned NUM_BYTES = 8;

	localparam logic [BYTE_W-1:0] START_RESET  = 8'hA8;
	localparam logic [BYTE_W-1:0] FINISH_RESET = 8'hA3;
	localparam logic [BYTE_W-1:0] EXT_MARK_B3  = 8'hFF;
	localparam logic [BYTE_W-1:0] EXT_MARK_B4  = 8'h0F;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH = 2'd1;

	// One decoded frame as it leaves the parser.
	typedef struct packed {
		logic                              hit;
		logic                              ext;
		logic [NUM_BYTES-1:0][BYTE_W-1:0]  bytes;
	} frame_t;

endpackage
`default_nettype wire

// ===== design/bfr_parser.sv =====
// Frame parser: phase tracking, byte store and frame checks.
`default_nettype none
module bfr_parser import bfr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic [BYTE_W-1:0] start_byte,
	input  wire logic [BYTE_W-1:0] finish_byte,
	output frame_t                 frame
);

	typedef enum logic [3:0] {
		PH_HUNT = 4'd0,
		PH_B1   = 4'd1,
		PH_B2   = 4'd2,
		PH_B3   = 4'd3,
		PH_B4   = 4'd4,
		PH_B5   = 4'd5,
		PH_B6   = 4'd6,
		PH_B7   = 4'd7,
		PH_B8   = 4'd8,
		PH_B9   = 4'd9,
		PH_B10  = 4'd10
	} phase_t;

	phase_t                 phase_q;
	phase_t                 phase_d;
	logic [8:0][BYTE_W-1:0] store_q;
	logic                   store_we;
	logic [3:0]             store_idx;
	logic [BYTE_W-1:0]      xor_lo;
	logic [BYTE_W-1:0]      xor_hi;
	logic                   is_ext_mark;
	logic                   norm_ok;
	logic                   ext_ok;

	assign xor_lo      = store_q[0] ^ store_q[1] ^ store_q[2] ^ store_q[3];
	assign xor_hi      = store_q[4] ^ store_q[5] ^ store_q[6] ^ store_q[7];
	assign is_ext_mark = (store_q[2] == EXT_MARK_B3) && (store_q[3] == EXT_MARK_B4);
	assign norm_ok     = (byte_in == finish_byte) && (xor_lo == store_q[4]);
	assign ext_ok      = (byte_in == finish_byte) && ((xor_lo ^ xor_hi) == store_q[8]);
	assign store_idx   = phase_q - 4'd1;

	always_comb begin
		phase_d   = PH_HUNT;
		store_we  = 1'b0;
		frame.hit = 1'b0;
		frame.ext = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				phase_d = (byte_in == start_byte) ? PH_B1 : PH_HUNT;
			end
			PH_B1: begin
				store_we = 1'b1;
				phase_d  = PH_B2;
			end
			PH_B2: begin
				store_we = 1'b1;
				phase_d  = PH_B3;
			end
			PH_B3: begin
				store_we = 1'b1;
				phase_d  = PH_B4;
			end
			PH_B4: begin
				store_we = 1'b1;
				phase_d  = PH_B5;
			end
			PH_B5: begin
				store_we = 1'b1;
				phase_d  = PH_B6;
			end
			PH_B6: begin
				// The extension marker wins over the finish check of a short frame.
				store_we = 1'b1;
				if (is_ext_mark) begin
					phase_d = PH_B7;
				end else begin
					frame.hit = norm_ok;
				end
			end
			PH_B7: begin
				store_we = 1'b1;
				phase_d  = PH_B8;
			end
			PH_B8: begin
				store_we = 1'b1;
				phase_d  = PH_B9;
			end
			PH_B9: begin
				store_we = 1'b1;
				phase_d  = PH_B10;
			end
			PH_B10: begin
				frame.hit = ext_ok;
				frame.ext = 1'b1;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		for (int k = 0; k < NUM_BYTES; k++) begin
			frame.bytes[k] = (frame.ext || k < 4) ? store_q[k] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_q[store_idx] <= byte_in;
		end
	end

endmodule
`default_nettype wire

// ===== design/bfr_out_reg.sv =====
// Result register that holds one accepted frame until it is taken.
`default_nettype none
module bfr_out_reg import bfr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire frame_t frame,
	input  wire logic   out_stall,
	output logic        out_valid,
	output logic        free,
	output frame_t      held
);

	logic   valid_q;
	frame_t frame_s2;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign held      = frame_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && frame.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && frame.hit) begin
			frame_s2 <= frame;
		end
	end

endmodule
`default_nettype wire

// ===== design/bus_frame_receiver_top.sv =====
// Top level of the bus frame receiver: input register, parser, result register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte              | in
//  result  | out_valid, out_stall, is_extended,       | out
//          | frame_b1 .. frame_b8                     |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One byte is accepted per cycle while in_stall is low. It is parsed from the input
// register; the step on a frame's last byte also loads the result register.
// The parser step is gated only by the result register, so a waiting frame
// stalls input only once the input register is also full.
// Reset clears the phase and the valid flags and loads the default start and finish bytes.
// Configuration writes are always taken (cfg_ready is tied high).
`default_nettype none
module bus_frame_receiver_top import bfr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      is_extended,
	output logic [BYTE_W-1:0]         frame_b1,
	output logic [BYTE_W-1:0]         frame_b2,
	output logic [BYTE_W-1:0]         frame_b3,
	output logic [BYTE_W-1:0]         frame_b4,
	output logic [BYTE_W-1:0]         frame_b5,
	output logic [BYTE_W-1:0]         frame_b6,
	output logic [BYTE_W-1:0]         frame_b7,
	output logic [BYTE_W-1:0]         frame_b8,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] finish_byte_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              free;
	logic              step;
	frame_t            frame;
	frame_t            held;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && free;
	assign in_stall  = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_RESET;
			finish_byte_q <= FINISH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START:  start_byte_q  <= cfg_data;
				CFG_FINISH: finish_byte_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	bfr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.byte_in     (byte_s1),
		.start_byte  (start_byte_q),
		.finish_byte (finish_byte_q),
		.frame       (frame)
	);

	bfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.frame     (frame),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (free),
		.held      (held)
	);

	assign is_extended = held.ext;
	assign frame_b1    = held.bytes[0];
	assign frame_b2    = held.bytes[1];
	assign frame_b3    = held.bytes[2];
	assign frame_b4    = held.bytes[3];
	assign frame_b5    = held.bytes[4];
	assign frame_b6    = held.bytes[5];
	assign frame_b7    = held.bytes[6];
	assign frame_b8    = held.bytes[7];

endmodule
`default_nettype wire

// ===== bench/bus_frame_receiver_top_test.sv =====
// Self-checking testbench for the bus frame receiver: random frames, random stalls, marker changes.
`timescale 1ns / 100ps
module bus_frame_receiver_top_test;
	import bfr_pkg::*;

	// Parser positions that matter to the frame tracker.
	localparam logic [3:0] PH_HUNT        = 4'd0;
	localparam logic [3:0] PH_NORMAL_LAST = 4'd6;
	localparam logic [3:0] PH_EXT_FIRST   = 4'd7;
	localparam logic [3:0] PH_EXT_LAST    = 4'd10;

	// Indexes that decode to no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	localparam int MAX_GAP         = 13;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 400;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 245;
	localparam int MAX_REPORTS     = 10;

	// Kinds of byte sequence the sender can produce.
	localparam int FK_NORMAL     = 0;
	localparam int FK_EXTENDED   = 1;
	localparam int FK_BAD_CHECK  = 2;
	localparam int FK_BAD_FINISH = 3;
	localparam int FK_EXT_BROKEN = 4;
	localparam int FK_TRUNCATED  = 5;
	localparam int FK_NOISE      = 6;

	class frame_tracker;
		logic [BYTE_W-1:0] start_val;
		logic [BYTE_W-1:0] finish_val;
		logic [3:0]        phase;
		logic [BYTE_W-1:0] store [9];
		frame_t            pending_frames [$];
		int                mismatches;

		function new();
			start_val  = START_RESET;
			finish_val = FINISH_RESET;
			phase      = PH_HUNT;
			mismatches = 0;
			foreach (store[k]) store[k] = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
			case (idx)
				CFG_START: start_val = data;
				CFG_FINISH: finish_val = data;
				default: ;
			endcase
		endfunction

		function logic [BYTE_W-1:0] xor_first(int count);
			logic [BYTE_W-1:0] acc;
			acc = '0;
			for (int k = 0; k < count; k++) acc ^= store[k];
			return acc;
		endfunction

		function void push_frame(logic ext);
			frame_t f;
			f.hit = 1'b1;
			f.ext = ext;
			for (int k = 0; k < NUM_BYTES; k++) f.bytes[k] = (ext || k < 4) ? store[k] : '0;
			pending_frames.push_back(f);
		endfunction

		// Advance the frame parser by one accepted byte.
		function void take_byte(logic [BYTE_W-1:0] b);
			case (phase)
				PH_HUNT: begin
					if (b == start_val) phase = 4'd1;
				end
				PH_NORMAL_LAST: begin
					store[5] = b;
					if (store[2] == EXT_MARK_B3 && store[3] == EXT_MARK_B4) begin
						phase = PH_EXT_FIRST;
					end else begin
						if (b == finish_val && xor_first(4) == store[4]) push_frame(1'b0);
						phase = PH_HUNT;
					end
				end
				PH_EXT_LAST: begin
					if (b == finish_val && xor_first(8) == store[8]) push_frame(1'b1);
					phase = PH_HUNT;
				end
				1, 2, 3, 4, 5, 7, 8, 9: begin
					store[phase - 1] = b;
					phase = phase + 4'd1;
				end
				default: phase = PH_HUNT;
			endcase
		endfunction

		function void note_mismatch(string field, int want, int got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on %s: expected %02h, got %02h", field, want, got);
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected frame: ext %0d, b1 %02h, b2 %02h", got.ext,
						got.bytes[0], got.bytes[1]);
				return;
			end
			want = pending_frames.pop_front();
			if (got.ext !== want.ext)
				note_mismatch("is_extended", int'(want.ext), int'(got.ext));
			for (int k = 0; k < NUM_BYTES; k++) begin
				if (got.bytes[k] !== want.bytes[k])
					note_mismatch($sformatf("frame_b%0d", k + 1), int'(want.bytes[k]),
						int'(got.bytes[k]));
			end
		endfunction

		function int pending();
			return pending_frames.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 is_extended;
	logic [BYTE_W-1:0]    frame_b1, frame_b2, frame_b3, frame_b4;
	logic [BYTE_W-1:0]    frame_b5, frame_b6, frame_b7, frame_b8;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	frame_tracker      tracker;
	logic [BYTE_W-1:0] cur_start = START_RESET;
	logic [BYTE_W-1:0] cur_finish = FINISH_RESET;
	bit                in_calm = 1'b0;
	int                phase_items;

	// Normal frame with extreme bytes, extended frame with the start byte as data and
	// the finish byte at position six, then a frame closed by the wrong finish byte.
	logic [BYTE_W-1:0] directed [25] = '{
		START_RESET, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, FINISH_RESET,
		START_RESET, 8'h01, START_RESET, 8'hFF, 8'h0F, 8'hFE, FINISH_RESET, 8'hAA, 8'h00,
		8'hAE, FINISH_RESET,
		START_RESET, 8'h12, 8'h34, 8'h56, 8'h78, 8'h08, 8'hA2
	};

	bus_frame_receiver_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_extended (is_extended),
		.frame_b1    (frame_b1),
		.frame_b2    (frame_b2),
		.frame_b3    (frame_b3),
		.frame_b4    (frame_b4),
		.frame_b5    (frame_b5),
		.frame_b6    (frame_b6),
		.frame_b7    (frame_b7),
		.frame_b8    (frame_b8),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Observe every transaction on the three channels.
	always @(posedge clk) begin
		frame_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) tracker.take_byte(rx_byte);
			if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				got.hit      = 1'b1;
				got.ext      = is_extended;
				got.bytes[0] = frame_b1;
				got.bytes[1] = frame_b2;
				got.bytes[2] = frame_b3;
				got.bytes[3] = frame_b4;
				got.bytes[4] = frame_b5;
				got.bytes[5] = frame_b6;
				got.bytes[6] = frame_b7;
				got.bytes[7] = frame_b8;
				tracker.check_frame(got);
			end
		end
	end

	// Result receiver: holds stall for a random number of cycles before each transaction.
	initial begin
		int hold;
		bit calm;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) calm = !calm;
			hold = calm ? 0 : $urandom_range(0, MAX_GAP);
			out_stall <= (hold != 0);
			repeat (hold) @(posedge clk);
			if (hold != 0) out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL bus_frame_receiver_top");
		$finish;
	end

	task send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold the sender off until every expected frame has come out and the pipe is empty.
	task wait_idle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Keeps cfg_valid high; the caller lowers it after the last write.
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task send_frame(input int kind);
		logic [BYTE_W-1:0] fb [1:10];
		int len;
		for (int k = 1; k <= 10; k++) fb[k] = pick_byte();
		len = 6;
		case (kind)
			FK_NORMAL, FK_BAD_CHECK, FK_BAD_FINISH: begin
				// Keep a normal frame from turning into an extended one by chance.
				if (fb[3] == EXT_MARK_B3 && fb[4] == EXT_MARK_B4) fb[4] = ~fb[4];
				fb[5] = fb[1] ^ fb[2] ^ fb[3] ^ fb[4];
				fb[6] = cur_finish;
				if (kind == FK_BAD_CHECK) fb[5] ^= BYTE_W'($urandom_range(1, 255));
				if (kind == FK_BAD_FINISH) fb[6] ^= BYTE_W'($urandom_range(1, 255));
			end
			FK_EXTENDED, FK_EXT_BROKEN: begin
				fb[3]  = EXT_MARK_B3;
				fb[4]  = EXT_MARK_B4;
				fb[9]  = fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5] ^ fb[6] ^ fb[7] ^ fb[8];
				fb[10] = cur_finish;
				if (kind == FK_EXT_BROKEN) begin
					if ($urandom_range(0, 1) == 0)
						fb[9] ^= BYTE_W'($urandom_range(1, 255));
					else
						fb[10] ^= BYTE_W'($urandom_range(1, 255));
				end
				len = 10;
			end
			FK_TRUNCATED: begin
				len = $urandom_range(1, 8);
				if (len >= 4 && $urandom_range(0, 1) == 0) begin
					fb[3] = EXT_MARK_B3;
					fb[4] = EXT_MARK_B4;
				end
			end
			default: len = $urandom_range(1, 6);
		endcase
		if (kind == FK_NOISE) begin
			for (int k = 1; k <= len; k++) send_byte(fb[k]);
			phase_items += len;
		end else begin
			send_byte(cur_start);
			for (int k = 1; k <= len; k++) send_byte(fb[k]);
			phase_items += len + 1;
		end
	endtask

	initial begin
		int r;
		int kind;
		logic [BYTE_W-1:0] s_val;
		logic [BYTE_W-1:0] f_val;
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k]) send_byte(directed[k]);
		phase_items = $size(directed);
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				wait_idle();
				case (p)
					1: begin s_val = 8'h00; f_val = 8'hFF; end
					2: begin s_val = 8'hFF; f_val = 8'h00; end
					4: begin s_val = 8'h55; f_val = 8'h55; end
					6: begin s_val = EXT_MARK_B4; f_val = EXT_MARK_B3; end
					7: begin s_val = START_RESET; f_val = FINISH_RESET; end
					default: begin
						s_val = BYTE_W'($urandom_range(0, 255));
						f_val = BYTE_W'($urandom_range(0, 255));
					end
				endcase
				// A write to an index past the two registers must leave both untouched.
				write_reg((p % 2 != 0) ? CFG_SPARE_A : CFG_SPARE_B,
					BYTE_W'($urandom_range(0, 255)));
				write_reg(CFG_START, s_val);
				write_reg(CFG_FINISH, f_val);
				cfg_valid <= 1'b0;
				cur_start   = s_val;
				cur_finish  = f_val;
				phase_items = 0;
			end
			while (phase_items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 5) == 0) in_calm = !in_calm;
				if ($urandom_range(0, 49) == 0) wait_idle();
				r = $urandom_range(0, 99);
				if (r < 40) kind = FK_NORMAL;
				else if (r < 70) kind = FK_EXTENDED;
				else if (r < 78) kind = FK_BAD_CHECK;
				else if (r < 84) kind = FK_BAD_FINISH;
				else if (r < 90) kind = FK_EXT_BROKEN;
				else if (r < 95) kind = FK_TRUNCATED;
				else kind = FK_NOISE;
				send_frame(kind);
			end
		end
		wait_idle();
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS bus_frame_receiver_top");
		else
			$display("FAIL bus_frame_receiver_top");
		$finish;
	end

endmodule
